### sv/slu4_pkg.sv
package slu4_pkg;

  typedef enum logic [1:0] {
    KIND_READ  = 2'd0,
    KIND_WRITE = 2'd1,
    KIND_POLL  = 2'd2,
    KIND_CLEAR = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    SEL_RX_CSR = 2'd0,
    SEL_RX_BUF = 2'd1,
    SEL_TX_CSR = 2'd2,
    SEL_TX_BUF = 2'd3
  } sel_t;

  // configuration register indexes (byte address / 4)
  localparam logic [1:0] REG_LF_BREAK = 2'd0;
  localparam logic [1:0] REG_VEC_BASE = 2'd1;
  localparam logic [1:0] REG_TX_DELAY = 2'd2;

  localparam logic [8:0] VEC_BASE_RST = 9'd48;
  localparam logic [7:0] TX_DELAY_RST = 8'd32;
  localparam logic [8:0] VEC_TX_OFS   = 9'd4;

  localparam logic [7:0] CH_LF       = 8'd10;
  localparam logic [7:0] CH_CR       = 8'd13;
  localparam logic [6:0] CH_STAR     = 7'd42;
  localparam logic [6:0] CH_STAR_MAP = 7'd4;
  localparam logic [6:0] CH_DC3      = 7'd19;
  localparam logic [6:0] CH_DC3_MAP  = 7'o34;

  localparam logic [7:0] WAIT_MAX = 8'hFF;

  // status word bits
  localparam int CSR_DONE_BIT = 7;
  localparam int CSR_IE_BIT   = 6;

  typedef struct packed {
    logic        lf_break_enable;
    logic [8:0]  irq_vector_base;
    logic [7:0]  tx_delay;
  } cfg_t;

  typedef struct packed {
    kind_t       kind;
    logic [1:0]  terminal;
    sel_t        reg_select;
    logic [15:0] write_data;
    logic        rx_valid;
    logic [7:0]  rx_char;
  } item_t;

  typedef struct packed {
    logic [15:0] read_data;
    logic        tx_valid;
    logic [6:0]  tx_char;
    logic        trap;
    logic        rx_irq;
    logic        tx_irq;
    logic [8:0]  rx_irq_vector;
    logic [8:0]  tx_irq_vector;
  } result_t;

endpackage

### sv/slu4_cfg.sv
module slu4_cfg (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [3:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  output slu4_pkg::cfg_t      cfg
);

  slu4_pkg::cfg_t cfg_r;
  logic           wr_en;
  logic [1:0]     reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign wr_en   = psel && penable && pwrite;
  assign cfg     = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.lf_break_enable <= 1'b0;
      cfg_r.irq_vector_base <= slu4_pkg::VEC_BASE_RST;
      cfg_r.tx_delay        <= slu4_pkg::TX_DELAY_RST;
    end else if (wr_en) begin
      case (reg_idx)
        slu4_pkg::REG_LF_BREAK: cfg_r.lf_break_enable <= pwdata[0];
        slu4_pkg::REG_VEC_BASE: cfg_r.irq_vector_base <= pwdata[8:0];
        slu4_pkg::REG_TX_DELAY: cfg_r.tx_delay        <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      slu4_pkg::REG_LF_BREAK: prdata = {31'd0, cfg_r.lf_break_enable};
      slu4_pkg::REG_VEC_BASE: prdata = {23'd0, cfg_r.irq_vector_base};
      slu4_pkg::REG_TX_DELAY: prdata = {24'd0, cfg_r.tx_delay};
      default:                prdata = 32'd0;
    endcase
  end

endmodule

### sv/slu4_unit.sv
module slu4_unit #(
  parameter int TERMINALS = 4
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                fire,
  input  slu4_pkg::item_t     item,
  input  slu4_pkg::cfg_t      cfg,
  output slu4_pkg::result_t   res
);

  localparam int IW = (TERMINALS > 1) ? $clog2(TERMINALS) : 1;

  logic [TERMINALS-1:0] rx_done_r;
  logic [TERMINALS-1:0] rx_ie_r;
  logic [TERMINALS-1:0] tx_ready_r;
  logic [TERMINALS-1:0] tx_ie_r;
  logic [6:0]           rx_buf_r  [TERMINALS];
  logic [6:0]           tx_buf_r  [TERMINALS];
  logic [7:0]           tx_wait_r [TERMINALS];

  logic [IW-1:0] t_idx;
  logic          hit;

  logic       rx_done_nxt;
  logic       rx_ie_nxt;
  logic       tx_ready_nxt;
  logic       tx_ie_nxt;
  logic       rx_buf_we;
  logic [6:0] rx_buf_nxt;
  logic       tx_buf_we;
  logic [7:0] tx_wait_nxt;
  logic [7:0] wait_inc;
  logic [6:0] rx_code;
  logic [8:0] rx_vec;

  assign t_idx  = IW'(item.terminal);
  assign hit    = (32'(item.terminal) < TERMINALS);
  assign rx_vec = cfg.irq_vector_base + 9'({item.terminal, 3'b000});

  always_comb begin
    rx_done_nxt  = rx_done_r[t_idx];
    rx_ie_nxt    = rx_ie_r[t_idx];
    tx_ready_nxt = tx_ready_r[t_idx];
    tx_ie_nxt    = tx_ie_r[t_idx];
    rx_buf_we    = 1'b0;
    tx_buf_we    = 1'b0;
    tx_wait_nxt  = tx_wait_r[t_idx];
    res          = '0;

    rx_code = item.rx_char[6:0];
    if (rx_code == slu4_pkg::CH_STAR) begin
      rx_code = slu4_pkg::CH_STAR_MAP;
    end else if (rx_code == slu4_pkg::CH_DC3) begin
      rx_code = slu4_pkg::CH_DC3_MAP;
    end
    rx_buf_nxt = rx_code;

    wait_inc = (tx_wait_r[t_idx] != slu4_pkg::WAIT_MAX) ?
               tx_wait_r[t_idx] + 8'd1 : tx_wait_r[t_idx];

    if (hit) begin
      case (item.kind)
        slu4_pkg::KIND_READ: begin
          case (item.reg_select)
            slu4_pkg::SEL_RX_CSR: begin
              res.read_data[slu4_pkg::CSR_DONE_BIT] = rx_done_r[t_idx];
              res.read_data[slu4_pkg::CSR_IE_BIT]   = rx_ie_r[t_idx];
            end
            slu4_pkg::SEL_RX_BUF: begin
              if (rx_done_r[t_idx]) begin
                rx_done_nxt    = 1'b0;
                res.read_data  = {9'd0, rx_buf_r[t_idx]};
              end
            end
            slu4_pkg::SEL_TX_CSR: begin
              res.read_data[slu4_pkg::CSR_DONE_BIT] = tx_ready_r[t_idx];
              res.read_data[slu4_pkg::CSR_IE_BIT]   = tx_ie_r[t_idx];
            end
            default: ;
          endcase
        end
        slu4_pkg::KIND_WRITE: begin
          case (item.reg_select)
            slu4_pkg::SEL_RX_CSR: rx_ie_nxt = item.write_data[slu4_pkg::CSR_IE_BIT];
            slu4_pkg::SEL_TX_CSR: tx_ie_nxt = item.write_data[slu4_pkg::CSR_IE_BIT];
            slu4_pkg::SEL_TX_BUF: begin
              tx_buf_we    = 1'b1;
              tx_ready_nxt = 1'b0;
              tx_wait_nxt  = 8'd0;
            end
            default: ;
          endcase
        end
        slu4_pkg::KIND_POLL: begin
          if (item.rx_valid) begin
            res.trap = cfg.lf_break_enable &&
                       (item.rx_char == slu4_pkg::CH_LF || item.rx_char == slu4_pkg::CH_CR);
            rx_buf_we   = 1'b1;
            rx_done_nxt = 1'b1;
            if (rx_ie_r[t_idx]) begin
              res.rx_irq        = 1'b1;
              res.rx_irq_vector = rx_vec;
            end
          end
          if (!tx_ready_r[t_idx]) begin
            tx_wait_nxt = wait_inc;
            if (wait_inc > cfg.tx_delay) begin
              res.tx_valid = 1'b1;
              res.tx_char  = tx_buf_r[t_idx];
              tx_ready_nxt = 1'b1;
              if (tx_ie_r[t_idx]) begin
                res.tx_irq        = 1'b1;
                res.tx_irq_vector = rx_vec + slu4_pkg::VEC_TX_OFS;
              end
            end
          end
        end
        slu4_pkg::KIND_CLEAR: begin
          // buffers are only visible behind done / not-ready, so they are left alone
          rx_done_nxt  = 1'b0;
          rx_ie_nxt    = 1'b0;
          tx_ready_nxt = 1'b1;
          tx_ie_nxt    = 1'b0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rx_done_r  <= '0;
      rx_ie_r    <= '0;
      tx_ready_r <= '1;
      tx_ie_r    <= '0;
      for (int i = 0; i < TERMINALS; i++) begin
        tx_wait_r[i] <= 8'd0;
      end
    end else if (fire && hit) begin
      rx_done_r[t_idx]  <= rx_done_nxt;
      rx_ie_r[t_idx]    <= rx_ie_nxt;
      tx_ready_r[t_idx] <= tx_ready_nxt;
      tx_ie_r[t_idx]    <= tx_ie_nxt;
      tx_wait_r[t_idx]  <= tx_wait_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && hit && rx_buf_we) begin
      rx_buf_r[t_idx] <= rx_buf_nxt;
    end
    if (fire && hit && tx_buf_we) begin
      tx_buf_r[t_idx] <= item.write_data[6:0];
    end
  end

endmodule

### sv/serial_line_unit_quad_top.sv
// Quad serial line unit.
// A transaction passes through the input register, then the result register.
// Throughput: one transaction per cycle; the input register advances whenever the
//   result register is empty or being taken.
// Reset (rst_n low, synchronous): pipeline empty, terminal flags and counters at
//   reset values, configuration registers at defaults.
module serial_line_unit_quad_top #(
  parameter int TERMINALS = 4
) (
  input  logic        clk,
  input  logic        rst_n,

  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_kind,
  input  logic [1:0]  in_terminal,
  input  logic [1:0]  in_reg_select,
  input  logic [15:0] in_write_data,
  input  logic        in_rx_valid,
  input  logic [7:0]  in_rx_char,

  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] out_read_data,
  output logic        out_tx_valid,
  output logic [6:0]  out_tx_char,
  output logic        out_trap,
  output logic        out_rx_irq,
  output logic        out_tx_irq,
  output logic [8:0]  out_rx_irq_vector,
  output logic [8:0]  out_tx_irq_vector,

  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  slu4_pkg::cfg_t    cfg;
  slu4_pkg::item_t   item_r;
  slu4_pkg::result_t res;
  slu4_pkg::result_t res_r;
  logic              in_valid_r;
  logic              out_valid_r;
  logic              adv;
  logic              in_take;

  assign adv      = in_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = in_valid_r && out_valid_r && out_stall;
  assign in_take  = in_valid && !in_stall;

  slu4_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  slu4_unit #(
    .TERMINALS (TERMINALS)
  ) u_unit (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (adv),
    .item  (item_r),
    .cfg   (cfg),
    .res   (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_take) begin
        in_valid_r <= 1'b1;
      end else if (adv) begin
        in_valid_r <= 1'b0;
      end
      if (adv) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      item_r.kind       <= slu4_pkg::kind_t'(in_kind);
      item_r.terminal   <= in_terminal;
      item_r.reg_select <= slu4_pkg::sel_t'(in_reg_select);
      item_r.write_data <= in_write_data;
      item_r.rx_valid   <= in_rx_valid;
      item_r.rx_char    <= in_rx_char;
    end
    if (adv) begin
      res_r <= res;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_read_data     = res_r.read_data;
  assign out_tx_valid      = res_r.tx_valid;
  assign out_tx_char       = res_r.tx_char;
  assign out_trap          = res_r.trap;
  assign out_rx_irq        = res_r.rx_irq;
  assign out_tx_irq        = res_r.tx_irq;
  assign out_rx_irq_vector = res_r.rx_irq_vector;
  assign out_tx_irq_vector = res_r.tx_irq_vector;

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid_r && out_stall))
    else $error("input stalled while result register free");

  a_txirq_needs_send: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_tx_irq) |-> out_tx_valid)
    else $error("transmit interrupt without a sent character");

  a_vectors_gated: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ((out_rx_irq || out_rx_irq_vector == 9'd0) &&
                     (out_tx_irq || out_tx_irq_vector == 9'd0)))
    else $error("interrupt vector without request");

  a_read_width: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_read_data[15:8] == 8'd0))
    else $error("read data beyond eight bits");

endmodule
